>>> design/heightgrid_vertex_normal_defines.svh
// ----------------------------------------------------------------------------
// Height-grid vertex normal: assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HEIGHTGRID_VERTEX_NORMAL_DEFINES_SVH
`define HEIGHTGRID_VERTEX_NORMAL_DEFINES_SVH
`ifndef SYNTH
// Plain property, checked at every clock edge outside reset.
`define HVN_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("heightgrid_vertex_normal assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define HVN_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("heightgrid_vertex_normal assertion failed");
`else
`define HVN_ASSERT(lbl, ck, rs, prop)
`define HVN_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

>>> design/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared constants of the height-grid vertex normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

  // Default grid side length.
  localparam int GRID_SIDE_DEF = 17;

  // Shared multiplier operand width.
  localparam int MUL_W = 32;

  // Q1.14 one.
  localparam logic [14:0] Q_ONE = 15'd16384;

  // Register reset values.
  localparam logic [15:0] STEP_RESET = 16'd8533;

  // Configuration register indexes.
  localparam logic [1:0] REG_CORNER_X  = 2'd0;
  localparam logic [1:0] REG_CORNER_Y  = 2'd1;
  localparam logic [1:0] REG_CELL_STEP = 2'd2;

endpackage

>>> design/heightgrid_vertex_normal.sv
// ----------------------------------------------------------------------------
// heightgrid_vertex_normal
// Takes a square height grid in raster order, keeps three rows in a line
// store and emits each vertex with world position and a Q1.14 unit normal.
// ----------------------------------------------------------------------------
// Each emitted vertex takes 5 store reads, multiplier passes for the squares and
// the position offsets, then three exact binary searches of up to 15 steps each,
// all on the one shared 32x32 multiplier. An item causes up to three vertices,
// so one item holds the input until the last of them is in the output register.
// The input is taken only while the sequencer is idle; a finished vertex waits
// in the output register while the next sample is taken.
// Synchronous reset clears control state and loads the register defaults.
`include "heightgrid_vertex_normal_defines.svh"

module heightgrid_vertex_normal #(
  parameter int GRID_SIDE = hvn_pkg::GRID_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         row,
  output logic [4:0]         col,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic [14:0]        normal_z,
  output logic               last_of_tile
);

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int DEPTH = 3 * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NEXT  = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_SLOPE = 4'd3;
  localparam logic [3:0] ST_QA    = 4'd4;
  localparam logic [3:0] ST_QB    = 4'd5;
  localparam logic [3:0] ST_QC    = 4'd6;
  localparam logic [3:0] ST_QD    = 4'd7;
  localparam logic [3:0] ST_QE    = 4'd8;
  localparam logic [3:0] ST_QF    = 4'd9;
  localparam logic [3:0] ST_ST    = 4'd10;
  localparam logic [3:0] ST_SL    = 4'd11;
  localparam logic [3:0] ST_SH    = 4'd12;
  localparam logic [3:0] ST_SC    = 4'd13;
  localparam logic [3:0] ST_POS   = 4'd14;

  // Slot of the row after or before a given one, rows rotate over three slots.
  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    slot_inc = (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    slot_dec = (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [AW-1:0] store_addr(input logic [1:0] s,
                                               input logic [CW-1:0] c);
    logic [AW-1:0] base;
    base = (s == 2'd0) ? AW'(0) : (s == 2'd1) ? AW'(GRID_SIDE) : AW'(2 * GRID_SIDE);
    store_addr = base + AW'(c);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[23:0];
    end
  endfunction

  logic [3:0]                state;
  logic signed [23:0]        corner_x;
  logic signed [23:0]        corner_y;
  logic [15:0]               cell_step;
  logic [CW-1:0]             in_r, in_c, cur_r, cur_c, vr, vc;
  logic [1:0]                in_slot, cur_slot, vslot;
  logic [2:0]                pend;
  logic [2:0]                rd_idx;
  logic [AW-1:0]             rd_addr;
  logic signed [15:0]        rd_data;
  logic signed [15:0]        z_rn, z_rp, z_cn, z_cp, z_c;
  logic [23:0]               ua, ub;
  logic                      sa, sb;
  logic [47:0]               ua_sq, ub_sq, mag_sq;
  logic [31:0]               s_sq;
  logic [49:0]               q;
  logic [22:0]               rs, cs;
  logic [1:0]                comp;
  logic [14:0]               lo, hi, mid, tval;
  logic [29:0]               tsq;
  logic [54:0]               acc;
  logic [79:0]               prod_full, rhs;
  logic [14:0]               nx, ny, nz;
  logic [hvn_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [2*hvn_pkg::MUL_W-1:0] mul_p;
  logic signed [16:0]        d_r, d_c;
  logic [15:0]               ad_r, ad_c;
  logic                      edge_r, edge_c;
  logic                      accept;
  logic signed [26:0]        dx, dy;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_x  <= '0;
      corner_y  <= '0;
      cell_step <= hvn_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hvn_pkg::REG_CORNER_X:  corner_x  <= cfg_data;
        hvn_pkg::REG_CORNER_Y:  corner_y  <= cfg_data;
        hvn_pkg::REG_CELL_STEP: cell_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Line store: three rows, written on each beat, read one word a cycle.
  logic signed [15:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[store_addr(in_slot, in_c)] <= height;
    end
    rd_data <= mem[rd_addr];
  end

  // Neighbour read order: row+1, row-1, col+1, col-1, centre; all clamped.
  always_comb begin
    unique case (rd_idx)
      3'd0:    rd_addr = store_addr((vr == LAST) ? vslot : slot_inc(vslot), vc);
      3'd1:    rd_addr = store_addr((vr == '0) ? vslot : slot_dec(vslot), vc);
      3'd2:    rd_addr = store_addr(vslot, (vc == LAST) ? vc : vc + CW'(1));
      3'd3:    rd_addr = store_addr(vslot, (vc == '0) ? vc : vc - CW'(1));
      default: rd_addr = store_addr(vslot, vc);
    endcase
  end

  // Slopes: one-sided at the grid border, halved central difference inside.
  assign d_r    = 17'(z_rn) - 17'(z_rp);
  assign d_c    = 17'(z_cn) - 17'(z_cp);
  assign ad_r   = d_r[16] ? 16'(-d_r) : d_r[15:0];
  assign ad_c   = d_c[16] ? 16'(-d_c) : d_c[15:0];
  assign edge_r = (vr == '0) || (vr == LAST);
  assign edge_c = (vc == '0) || (vc == LAST);

  // Binary search step values and the exact compare.
  assign mid       = 15'((17'(lo) + 17'(hi) + 17'd1) >> 1);
  assign tval      = 15'({1'b0, mid, 1'b0} - 17'd1);
  assign mag_sq    = (comp == 2'd0) ? ua_sq : (comp == 2'd1) ? ub_sq : 48'(s_sq);
  assign prod_full = {mul_p[54:0], 25'd0} + 80'(acc);
  assign rhs       = {2'b00, mag_sq, 30'd0};

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_QA: begin
        mul_a = 32'(ua);
        mul_b = 32'(ua);
      end
      ST_QB: begin
        mul_a = 32'(ub);
        mul_b = 32'(ub);
      end
      ST_QC: begin
        mul_a = 32'(cell_step);
        mul_b = 32'(cell_step);
      end
      ST_QD: begin
        mul_a = 32'(vr);
        mul_b = 32'(cell_step);
      end
      ST_QE: begin
        mul_a = 32'(vc);
        mul_b = 32'(cell_step);
      end
      ST_ST: begin
        mul_a = 32'(tval);
        mul_b = 32'(tval);
      end
      ST_SL: begin
        mul_a = 32'(mul_p[29:0]);
        mul_b = 32'(q[24:0]);
      end
      ST_SH: begin
        mul_a = 32'(tsq);
        mul_b = 32'(q[49:25]);
      end
      default: ;
    endcase
  end

  hvn_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // World position before saturation.
  assign dx = 27'(corner_x) - $signed({4'd0, rs});
  assign dy = 27'(corner_y) - $signed({4'd0, cs});

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_r      <= '0;
      in_c      <= '0;
      in_slot   <= '0;
      pend      <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      // Free the output register once its beat is taken, unless a new one loads.
      if (out_valid && out_ready && (state != ST_POS)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_r    <= in_r;
            cur_c    <= in_c;
            cur_slot <= in_slot;
            pend     <= {(in_r == LAST) && (in_c == LAST),
                         (in_r == LAST) && (in_c != '0),
                         (in_r != '0)};
            state    <= ST_NEXT;
            if (in_c == LAST) begin
              in_c <= '0;
              if (in_r == LAST) begin
                in_r    <= '0;
                in_slot <= '0;
              end else begin
                in_r    <= in_r + CW'(1);
                in_slot <= slot_inc(in_slot);
              end
            end else begin
              in_c <= in_c + CW'(1);
            end
          end
        end
        ST_NEXT: begin
          rd_idx <= '0;
          state  <= ST_RD;
          if (pend[0]) begin
            vr    <= cur_r - CW'(1);
            vc    <= cur_c;
            vslot <= slot_dec(cur_slot);
            pend  <= {pend[2:1], 1'b0};
          end else if (pend[1]) begin
            vr    <= cur_r;
            vc    <= cur_c - CW'(1);
            vslot <= cur_slot;
            pend  <= {pend[2], 2'b00};
          end else if (pend[2]) begin
            vr    <= cur_r;
            vc    <= cur_c;
            vslot <= cur_slot;
            pend  <= '0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RD: begin
          rd_idx <= rd_idx + 3'd1;
          unique case (rd_idx)
            3'd1:    z_rn <= rd_data;
            3'd2:    z_rp <= rd_data;
            3'd3:    z_cn <= rd_data;
            3'd4:    z_cp <= rd_data;
            3'd5:    z_c  <= rd_data;
            default: ;
          endcase
          if (rd_idx == 3'd5) begin
            state <= ST_SLOPE;
          end
        end
        ST_SLOPE: begin
          ua    <= edge_r ? {ad_r, 8'd0} : {1'b0, ad_r, 7'd0};
          ub    <= edge_c ? {ad_c, 8'd0} : {1'b0, ad_c, 7'd0};
          sa    <= d_r[16];
          sb    <= d_c[16];
          state <= ST_QA;
        end
        ST_QA: state <= ST_QB;
        ST_QB: begin
          ua_sq <= mul_p[47:0];
          state <= ST_QC;
        end
        ST_QC: begin
          ub_sq <= mul_p[47:0];
          state <= ST_QD;
        end
        ST_QD: begin
          s_sq  <= mul_p[31:0];
          state <= ST_QE;
        end
        ST_QE: begin
          rs    <= mul_p[22:0];
          q     <= 50'(ua_sq) + 50'(ub_sq) + 50'(s_sq);
          state <= ST_QF;
        end
        ST_QF: begin
          cs   <= mul_p[22:0];
          comp <= 2'd0;
          lo   <= '0;
          hi   <= hvn_pkg::Q_ONE;
          // Zero step with flat ground points straight up.
          if (q == '0) begin
            nx    <= '0;
            ny    <= '0;
            nz    <= hvn_pkg::Q_ONE;
            state <= ST_POS;
          end else begin
            state <= ST_ST;
          end
        end
        ST_ST: begin
          if (lo < hi) begin
            state <= ST_SL;
          end else begin
            unique case (comp)
              2'd0:    nx <= lo;
              2'd1:    ny <= lo;
              default: nz <= lo;
            endcase
            if (comp == 2'd2) begin
              state <= ST_POS;
            end else begin
              comp <= comp + 2'd1;
              lo   <= '0;
              hi   <= hvn_pkg::Q_ONE;
            end
          end
        end
        ST_SL: begin
          tsq   <= mul_p[29:0];
          state <= ST_SH;
        end
        ST_SH: begin
          acc   <= mul_p[54:0];
          state <= ST_SC;
        end
        ST_SC: begin
          if (prod_full <= rhs) begin
            lo <= mid;
          end else begin
            hi <= mid - 15'd1;
          end
          state <= ST_ST;
        end
        ST_POS: begin
          // Load the result beat once the output register is free.
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            row          <= 5'(vr);
            col          <= 5'(vc);
            pos_x        <= sat24(dx);
            pos_y        <= sat24(dy);
            pos_z        <= z_c;
            normal_x     <= sa ? (16'd0 - {1'b0, nx}) : {1'b0, nx};
            normal_y     <= sb ? (16'd0 - {1'b0, ny}) : {1'b0, ny};
            normal_z     <= nz;
            last_of_tile <= (vr == LAST) && (vc == LAST);
            state        <= ST_NEXT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  `HVN_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `HVN_ASSERT(a_search_bounds, clk, rst, (state == ST_SC) |-> (lo <= hi && hi <= hvn_pkg::Q_ONE))
  `HVN_ASSERT_NEXT(a_hold_result, clk, rst, state == ST_POS && out_valid && !out_ready, state == ST_POS)
  `HVN_ASSERT(a_col_range, clk, rst, in_c <= LAST)

endmodule

>>> design/hvn_mul.sv
// ----------------------------------------------------------------------------
// hvn_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module hvn_mul (
  input  logic                            clk,
  input  logic [hvn_pkg::MUL_W-1:0]       a,
  input  logic [hvn_pkg::MUL_W-1:0]       b,
  output logic [2*hvn_pkg::MUL_W-1:0]     p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> verif/heightgrid_vertex_normal_tb.sv
// ----------------------------------------------------------------------------
// heightgrid_vertex_normal_tb
// Streams height samples into the block under several register settings
// and idle patterns. A built-in line-store model predicts every vertex:
// world position, height and exact rounded Q1.14 normal, checked per field.
// ----------------------------------------------------------------------------
module heightgrid_vertex_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = hvn_pkg::GRID_SIDE_DEF;
  localparam int TEST_SAMPLES = 33;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0]        normal_z;
    logic               last_of_tile;
  } vertex_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] height;
  logic               out_valid;
  logic               out_ready;
  logic [4:0]         row;
  logic [4:0]         col;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic [14:0]        normal_z;
  logic               last_of_tile;

  heightgrid_vertex_normal dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .height(height),
    .out_valid(out_valid), .out_ready(out_ready),
    .row(row), .col(col), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .last_of_tile(last_of_tile)
  );

  // Model state: line store, next sample position and register copies.
  logic signed [15:0] line_store [3*SIDE];
  int                 next_row;
  int                 next_col;
  logic signed [23:0] tile_corner_x;
  logic signed [23:0] tile_corner_y;
  logic [15:0]        tile_step;

  vertex_t pending_vertices[$];
  int      error_count;
  int      heights_sent;
  int      vertices_checked;
  int      tiles_done;
  int      sender_idle_pct;
  int      receiver_stall_pct;
  int      cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Height at a clamped grid position.
  function automatic longint stored_height(int r, int c);
    if (r < 0) r = 0;
    if (r > SIDE - 1) r = SIDE - 1;
    if (c < 0) c = 0;
    if (c > SIDE - 1) c = SIDE - 1;
    return longint'(line_store[(r % 3) * SIDE + c]);
  endfunction

  // Central difference halved inside, one-sided difference at the edges.
  function automatic longint slope(int idx, longint z_next, longint z_prev);
    if (idx > 0 && idx < SIDE - 1) return (z_next - z_prev) * 128;
    return (z_next - z_prev) * 256;
  endfunction

  // Largest n in 0..16384 with (2n-1)^2 * q <= 2^30 * mag^2, which is
  // 16384*mag/sqrt(q) rounded to nearest with ties away from zero.
  function automatic logic [14:0] unit_component(longint unsigned mag,
                                                 longint unsigned q);
    logic [127:0]    bound;
    logic [127:0]    prod;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    bound = 128'(mag * mag) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      prod = 128'(t * t) * 128'(q);
      if (prod <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  function automatic logic signed [23:0] world_coord(logic signed [23:0] base,
                                                     int idx);
    longint v;
    v = longint'(base) - longint'(idx) * longint'(tile_step);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic vertex_t vertex_at(int r, int c);
    vertex_t         v;
    longint          a;
    longint          b;
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned s;
    longint unsigned q;
    logic [15:0]     nx;
    logic [15:0]     ny;
    a = slope(r, stored_height(r + 1, c), stored_height(r - 1, c));
    b = slope(c, stored_height(r, c + 1), stored_height(r, c - 1));
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    s = tile_step;
    q = ua * ua + ub * ub + s * s;
    if (q == 0) begin
      nx = '0;
      ny = '0;
      v.normal_z = hvn_pkg::Q_ONE;
    end else begin
      nx = {1'b0, unit_component(ua, q)};
      ny = {1'b0, unit_component(ub, q)};
      v.normal_z = unit_component(s, q);
    end
    v.row = r[4:0];
    v.col = c[4:0];
    v.pos_x = world_coord(tile_corner_x, r);
    v.pos_y = world_coord(tile_corner_y, c);
    v.pos_z = 16'(stored_height(r, c));
    v.normal_x = (a < 0) ? -nx : nx;
    v.normal_y = (b < 0) ? -ny : ny;
    v.last_of_tile = (r == SIDE - 1 && c == SIDE - 1);
    return v;
  endfunction

  // Append one predicted vertex to the tail of the queue.
  task automatic queue_vertex(vertex_t v);
    pending_vertices.insert(pending_vertices.size(), v);
  endtask

  // Store one sample and queue the vertices it completes.
  task automatic take_height(logic signed [15:0] h);
    line_store[(next_row % 3) * SIDE + next_col] = h;
    if (next_row >= 1) queue_vertex(vertex_at(next_row - 1, next_col));
    if (next_row == SIDE - 1 && next_col >= 1)
      queue_vertex(vertex_at(next_row, next_col - 1));
    if (next_row == SIDE - 1 && next_col == SIDE - 1)
      queue_vertex(vertex_at(next_row, next_col));
    if (next_col + 1 < SIDE) begin
      next_col++;
    end else begin
      next_col = 0;
      if (next_row + 1 < SIDE) begin
        next_row++;
      end else begin
        next_row = 0;
        tiles_done++;
      end
    end
  endtask

  // Send one height beat; valid stays high so back-to-back beats need no gap.
  task automatic send_height(logic signed [15:0] h);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (sender_idle_pct > 0 && $urandom_range(15) == 0) gap += $urandom_range(300);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    take_height(h);
    heights_sent++;
  endtask

  // Drop valid and wait until every queued vertex has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hvn_pkg::REG_CORNER_X: tile_corner_x = value;
      hvn_pkg::REG_CORNER_Y: tile_corner_y = value;
      hvn_pkg::REG_CELL_STEP: tile_step = value[15:0];
      default: ;
    endcase
  endtask

  // Result checker.
  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_vertices.size() == 0) begin
          $error("vertex (%0d,%0d) with none expected", row, col);
          error_count++;
        end else begin
          want = pending_vertices.pop_front();
          vertices_checked++;
          if (row !== want.row) begin
            $error("row: expected %0d got %0d", want.row, row); error_count++;
          end
          if (col !== want.col) begin
            $error("col: expected %0d got %0d", want.col, col); error_count++;
          end
          if (pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d got %0d", want.pos_x, pos_x); error_count++;
          end
          if (pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d got %0d", want.pos_y, pos_y); error_count++;
          end
          if (pos_z !== want.pos_z) begin
            $error("pos_z: expected %0d got %0d", want.pos_z, pos_z); error_count++;
          end
          if (normal_x !== want.normal_x) begin
            $error("normal_x: expected %0d got %0d", want.normal_x, normal_x);
            error_count++;
          end
          if (normal_y !== want.normal_y) begin
            $error("normal_y: expected %0d got %0d", want.normal_y, normal_y);
            error_count++;
          end
          if (normal_z !== want.normal_z) begin
            $error("normal_z: expected %0d got %0d", want.normal_z, normal_z);
            error_count++;
          end
          if (last_of_tile !== want.last_of_tile) begin
            $error("last_of_tile: expected %0d got %0d", want.last_of_tile,
                   last_of_tile);
            error_count++;
          end
        end
      end
    end
  end

  // Reset defaults, then extreme heights to drive the steepest slopes, also
  // alternating extremes early in the second row; the rest is random. No idling.
  task automatic test_extreme_heights();
    logic signed [15:0] picks [16];
    picks = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sh5555,
              -16'sd21846, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
              16'sd100, -16'sd100, 16'sd0, 16'sd32767, -16'sd32768};
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < TEST_SAMPLES; i++) begin
      if (i < 16) send_height(picks[i]);
      else if (i >= SIDE && i < SIDE + 9) send_height((i % 2) ? 16'sh7FFF : 16'sh8000);
      else send_height(16'($urandom));
    end
  endtask

  // Zero cell step on mostly flat ground gives the degenerate normal;
  // corners at both extremes. Sender idles often.
  task automatic test_flat_zero_step();
    write_reg(hvn_pkg::REG_CELL_STEP, 24'd0);
    write_reg(hvn_pkg::REG_CORNER_X, 24'h7FFFFF);
    write_reg(hvn_pkg::REG_CORNER_Y, 24'h800000);
    sender_idle_pct = 64;
    receiver_stall_pct = 0;
    for (int i = 0; i < TEST_SAMPLES; i++) begin
      if ($urandom_range(9) == 0) send_height(16'($urandom));
      else send_height(16'sd1234);
    end
  endtask

  // Largest step with the north corner at the negative limit, so world X
  // saturates. Receiver stalls often.
  task automatic test_wide_step();
    write_reg(hvn_pkg::REG_CELL_STEP, 24'd65535);
    write_reg(hvn_pkg::REG_CORNER_X, 24'h800000);
    write_reg(hvn_pkg::REG_CORNER_Y, 24'hF80000);
    sender_idle_pct = 0;
    receiver_stall_pct = 64;
    for (int i = 0; i < TEST_SAMPLES; i++) send_height(16'($urandom));
  endtask

  // Gentle random terrain with both sides idling; halfway through the
  // sender waits for the block to empty and the step is changed mid-tile.
  task automatic test_rolling_terrain();
    logic signed [15:0] h;
    write_reg(hvn_pkg::REG_CELL_STEP, 24'd1);
    write_reg(hvn_pkg::REG_CORNER_X, 24'($urandom));
    write_reg(hvn_pkg::REG_CORNER_Y, 24'($urandom));
    sender_idle_pct = 29;
    receiver_stall_pct = 29;
    h = 16'($urandom);
    for (int i = 0; i < TEST_SAMPLES; i++) begin
      if (i == TEST_SAMPLES / 2)
        write_reg(hvn_pkg::REG_CELL_STEP, 24'($urandom_range(65535, 1)));
      if ($urandom_range(7) == 0) h = 16'($urandom);
      else h = h + $signed(16'($urandom_range(64))) - 16'sd32;
      send_height(h);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = hvn_pkg::REG_CORNER_X;
    cfg_data = '0;
    in_valid = 1'b0;
    height = '0;
    cycle_count = 0;
    error_count = 0;
    heights_sent = 0;
    vertices_checked = 0;
    tiles_done = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    next_row = 0;
    next_col = 0;
    tile_corner_x = '0;
    tile_corner_y = '0;
    tile_step = hvn_pkg::STEP_RESET;
    foreach (line_store[i]) line_store[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_heights();
    test_flat_zero_step();
    test_wide_step();
    test_rolling_terrain();

    drain();
    $display("Sent %0d heights and checked %0d vertices, %0d whole tiles,",
             heights_sent, vertices_checked, tiles_done);
    $display("with zero and extreme steps, saturated corners, mid-tile step change.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
